[rtl/core/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("deque assertion failed");
// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("deque assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/cad_pkg.sv]
`timescale 1ns / 1ps

package cad_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_REAR  = 2'd1,
        OP_REM_FRONT = 2'd2,
        OP_REM_REAR  = 2'd3
    } operation_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // per-cycle command to one chain; at most one bit is set
    typedef struct packed {
        logic push_head;
        logic pop_head;
        logic push_tail;
        logic pop_tail;
    } chain_ctl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } cell_link_t;

endpackage

[rtl/core/cad_cell.sv]
`timescale 1ns / 1ps

module cad_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cad_pkg::chain_ctl_t        ctl,
    input  logic [cad_pkg::DATA_W-1:0] new_data,
    input  cad_pkg::cell_link_t        left_i,
    input  cad_pkg::cell_link_t        right_i,
    output cad_pkg::cell_link_t        cell_o
);
    import cad_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.push_head) begin
            valid_next = left_i.valid;
            data_next  = left_i.data;
        end else if (ctl.pop_head) begin
            valid_next = right_i.valid;
            data_next  = right_i.data;
        end else if (ctl.push_tail && !valid_reg && left_i.valid) begin
            // first free cell takes the word
            valid_next = 1'b1;
            data_next  = new_data;
        end else if (ctl.pop_tail && valid_reg && !right_i.valid) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign cell_o.valid = valid_reg;
    assign cell_o.data  = data_reg;

endmodule

[rtl/core/cad_chain.sv]
`timescale 1ns / 1ps

module cad_chain #(
    parameter int DEPTH = 128
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cad_pkg::chain_ctl_t        ctl,
    input  logic [cad_pkg::DATA_W-1:0] new_data,
    output cad_pkg::cell_link_t        head_o
);
    import cad_pkg::*;

    cell_link_t cells [DEPTH];
    cell_link_t lefts [DEPTH];
    cell_link_t rights [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_first
                // the head cell sees the incoming word as an always-valid neighbor
                assign lefts[i] = '{valid: 1'b1, data: new_data};
            end else begin : g_mid
                assign lefts[i] = cells[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign rights[i] = '0;
            end else begin : g_inner
                assign rights[i] = cells[i+1];
            end

            cad_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .new_data (new_data),
                .left_i   (lefts[i]),
                .right_i  (rights[i]),
                .cell_o   (cells[i])
            );
        end
    endgenerate

    assign head_o = cells[0];

endmodule

[rtl/core/circular_array_deque.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fixed-capacity deque, CAPACITY 32-bit words. Each input word carries one
// operation (insert front, insert rear, remove front, remove rear); each gives
// one result word in the cycle after it is taken: status, occupancy after the
// operation, and the front and rear values (zero when the deque is empty).
// Storage is two rows of CAPACITY cells, one ordered from the front and one
// from the rear, so both ends sit in fixed cells and every operation is a
// shift or local write in the rows. One operation per clock is sustained as
// long as results are taken; the output register lets the next word in while
// the current result is being taken. Reset empties the deque.
module circular_array_deque #(
    parameter int CAPACITY = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cad_pkg::OP_W-1:0]          s_operation,
    input  logic signed [cad_pkg::DATA_W-1:0] s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cad_pkg::STAT_W-1:0]        m_status,
    output logic [cad_pkg::OCC_W-1:0]         m_occupancy,
    output logic signed [cad_pkg::DATA_W-1:0] m_front_value,
    output logic signed [cad_pkg::DATA_W-1:0] m_rear_value
);
    import cad_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    operation_t  op;
    logic        in_acc;
    logic        is_ins;
    logic        full;
    logic        empty;
    chain_ctl_t  front_ctl;
    chain_ctl_t  rear_ctl;
    cell_link_t  front_head;
    cell_link_t  rear_head;

    assign op     = operation_t'(s_operation);
    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc = s_valid && s_ready;
    assign is_ins = (op == OP_INS_FRONT) || (op == OP_INS_REAR);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    always_comb begin
        front_ctl   = '0;
        rear_ctl    = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (in_acc) begin
            status_next = ST_DONE;
            if (is_ins && full) begin
                status_next = ST_FULL;
            end else if (!is_ins && empty) begin
                status_next = ST_EMPTY;
            end else begin
                count_next = is_ins ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
                unique case (op)
                    OP_INS_FRONT: begin
                        front_ctl.push_head = 1'b1;
                        rear_ctl.push_tail  = 1'b1;
                    end
                    OP_INS_REAR: begin
                        front_ctl.push_tail = 1'b1;
                        rear_ctl.push_head  = 1'b1;
                    end
                    OP_REM_FRONT: begin
                        front_ctl.pop_head = 1'b1;
                        rear_ctl.pop_tail  = 1'b1;
                    end
                    OP_REM_REAR: begin
                        front_ctl.pop_tail = 1'b1;
                        rear_ctl.pop_head  = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        m_valid_next = in_acc ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
    end

    cad_chain #(
        .DEPTH (CAPACITY)
    ) u_front_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (front_ctl),
        .new_data (s_item_value),
        .head_o   (front_head)
    );

    cad_chain #(
        .DEPTH (CAPACITY)
    ) u_rear_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rear_ctl),
        .new_data (s_item_value),
        .head_o   (rear_head)
    );

    // chains and count only move when the output register loads, so these hold
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_occupancy   = OCC_W'(count_reg);
    assign m_front_value = empty ? '0 : $signed(front_head.data);
    assign m_rear_value  = empty ? '0 : $signed(rear_head.data);

    `ASSERT_CLK(a_heads_track_count, aclk, aresetn,
        (front_head.valid == !empty) && (rear_head.valid == !empty))
    `ASSERT_ALWAYS(a_count_in_range, aclk, !aresetn || (count_reg <= CNT_W'(CAPACITY)))
    `ASSERT_CLK(a_full_rejects, aclk, aresetn,
        (in_acc && is_ins && full) |=> (m_valid && m_status == ST_FULL && full))
    `ASSERT_CLK(a_empty_rejects, aclk, aresetn,
        (in_acc && !is_ins && empty) |=> (m_valid && m_status == ST_EMPTY && empty))
    `ASSERT_CLK(a_stall_holds_state, aclk, aresetn,
        (m_valid && !m_ready) |=> $stable(count_reg))

endmodule

[test/deque_checker.sv]
`timescale 1ns / 1ps

module deque_checker #(
    parameter int CAPACITY = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [cad_pkg::OP_W-1:0]          s_operation,
    input  logic signed [cad_pkg::DATA_W-1:0] s_item_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [cad_pkg::STAT_W-1:0]        m_status,
    input  logic [cad_pkg::OCC_W-1:0]         m_occupancy,
    input  logic signed [cad_pkg::DATA_W-1:0] m_front_value,
    input  logic signed [cad_pkg::DATA_W-1:0] m_rear_value,
    output int                                mismatch_count,
    output int                                pending_count,
    output int                                checked_count,
    output int                                full_rejects,
    output int                                empty_rejects,
    output int                                peak_occupancy
);
    import cad_pkg::*;

    typedef struct packed {
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  rear_value;
    } deque_result_t;

    logic signed [DATA_W-1:0] slots [CAPACITY];
    int unsigned              head_idx;
    int unsigned              tail_idx;
    int unsigned              fill;
    deque_result_t            expected_results [$];

    function automatic int unsigned next_idx(int unsigned i);
        return (i >= CAPACITY - 1) ? 0 : i + 1;
    endfunction

    function automatic int unsigned prev_idx(int unsigned i);
        return (i == 0) ? CAPACITY - 1 : i - 1;
    endfunction

    task automatic apply_operation(input operation_t op, input logic signed [DATA_W-1:0] value,
                                   output deque_result_t res);
        res.status = ST_DONE;
        if (op == OP_INS_FRONT || op == OP_INS_REAR) begin
            if (fill >= CAPACITY) begin
                res.status = ST_FULL;
                full_rejects++;
            end else begin
                // first word always lands in slot 0, both ends point at it
                if (fill == 0) begin
                    head_idx = 0;
                    tail_idx = 0;
                    slots[0] = value;
                end else if (op == OP_INS_FRONT) begin
                    head_idx = prev_idx(head_idx);
                    slots[head_idx] = value;
                end else begin
                    tail_idx = next_idx(tail_idx);
                    slots[tail_idx] = value;
                end
                fill++;
            end
        end else begin
            if (fill == 0) begin
                res.status = ST_EMPTY;
                empty_rejects++;
            end else begin
                // indices stay put when the last word leaves
                if (fill > 1) begin
                    if (op == OP_REM_FRONT) head_idx = next_idx(head_idx);
                    else tail_idx = prev_idx(tail_idx);
                end
                fill--;
            end
        end
        if (fill > peak_occupancy) peak_occupancy = fill;
        res.occupancy = fill[OCC_W-1:0];
        res.front_value = (fill != 0) ? slots[head_idx] : '0;
        res.rear_value  = (fill != 0) ? slots[tail_idx] : '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : monitor
        deque_result_t res;
        if (!aresetn) begin
            head_idx = 0;
            tail_idx = 0;
            fill = 0;
            expected_results.delete();
            mismatch_count = 0;
            checked_count = 0;
            full_rejects = 0;
            empty_rejects = 0;
            peak_occupancy = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_operation(operation_t'(s_operation), s_item_value, res);
                expected_results.push_back(res);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    res = expected_results.pop_front();
                    checked_count++;
                    if (m_status !== res.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  m_status, res.status));
                    if (m_occupancy !== res.occupancy)
                        report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                                  m_occupancy, res.occupancy));
                    if (m_front_value !== res.front_value)
                        report_mismatch($sformatf("front got %h, expected %h",
                                                  m_front_value, res.front_value));
                    if (m_rear_value !== res.rear_value)
                        report_mismatch($sformatf("rear got %h, expected %h",
                                                  m_rear_value, res.rear_value));
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cad_pkg::*;

    localparam int DEPTH       = 128;
    localparam int STALL_LIMIT = 400;
    localparam int SEG_WORDS   = 100;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation;
    logic signed [DATA_W-1:0] s_item_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [STAT_W-1:0]        m_status;
    logic [OCC_W-1:0]         m_occupancy;
    logic signed [DATA_W-1:0] m_front_value;
    logic signed [DATA_W-1:0] m_rear_value;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int full_rejects;
    int empty_rejects;
    int peak_occupancy;
    int idle_cycles;
    int sent_words;
    bit burst;

    circular_array_deque #(.CAPACITY(DEPTH)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value)
    );

    deque_checker #(.CAPACITY(DEPTH)) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_item_value   (s_item_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy),
        .m_front_value  (m_front_value),
        .m_rear_value   (m_rear_value),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .full_rejects   (full_rejects),
        .empty_rejects  (empty_rejects),
        .peak_occupancy (peak_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic operation_t pick_operation(int unsigned insert_pct);
        logic front_end;
        front_end = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < insert_pct) return front_end ? OP_INS_FRONT : OP_INS_REAR;
        return front_end ? OP_REM_FRONT : OP_REM_REAR;
    endfunction

    // returns just after the edge that takes the word
    task automatic send_word(input operation_t op, input logic signed [DATA_W-1:0] value);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_item_value = value;
        do @(posedge aclk); while (!s_ready);
        sent_words++;
    endtask

    // result side: random stall before each word
    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 12);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned insert_pct [6];
        insert_pct = '{90, 90, 10, 10, 50, 50};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_INS_FRONT;
        s_item_value = '0;
        m_ready = 1'b0;
        sent_words = 0;
        burst = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty rejects, wrap of the head on the second front insert, value extremes
        send_word(OP_REM_FRONT, 32'h1234_5678);
        send_word(OP_REM_REAR, 32'h8765_4321);
        send_word(OP_INS_FRONT, 32'h7fff_ffff);
        send_word(OP_INS_FRONT, 32'h8000_0000);
        send_word(OP_INS_REAR, '0);
        send_word(OP_INS_REAR, '1);
        send_word(OP_REM_REAR, '0);
        send_word(OP_REM_FRONT, '0);
        send_word(OP_REM_FRONT, '0);
        send_word(OP_REM_FRONT, '0);    // last word leaves
        send_word(OP_REM_REAR, '0);
        // insert after drain restarts both ends at slot 0
        send_word(OP_INS_REAR, 32'h5555_5555);
        send_word(OP_INS_REAR, 32'haaaa_aaaa);
        send_word(OP_REM_REAR, '0);
        send_word(OP_REM_REAR, '0);
        send_word(OP_INS_FRONT, pick_value());
        send_word(OP_INS_REAR, pick_value());
        send_word(OP_REM_FRONT, '0);
        send_word(OP_REM_FRONT, '0);

        // fill past full, drain past empty, then mixed traffic
        for (int seg = 0; seg < 6; seg++) begin
            for (int n = 0; n < SEG_WORDS; n++) begin
                if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                send_word(pick_operation(insert_pct[seg]), pick_value());
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d words sent, %0d results checked, peak occupancy %0d of %0d",
                 sent_words, checked_count, peak_occupancy, DEPTH);
        $display("%0d inserts rejected as full, %0d removals rejected as empty",
                 full_rejects, empty_rejects);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
